/* sv/rpla_pkg.sv */
// shared constants, types and helpers for the reward-penalty learning automaton
`default_nettype none
package rpla_pkg;

   localparam int NUM_ACTIONS = 16;
   localparam int IDX_W = $clog2(NUM_ACTIONS);
   localparam int PROB_W = 16;
   localparam int RATE_W = 16;
   localparam int CNT_W = 32;
   localparam int CSR_IDX_W = 2;

   localparam logic [PROB_W-1:0] PROB_RESET = PROB_W'(65536 / NUM_ACTIONS);
   localparam logic [RATE_W-1:0] REWARD_RATE_RESET = 16'd4096;
   localparam logic [RATE_W-1:0] PENALTY_RATE_RESET = 16'd4096;
   localparam logic [RATE_W-1:0] PENALTY_SHARE_RESET = 16'd273;
   localparam logic [IDX_W-1:0] LAST_ACTION = IDX_W'(NUM_ACTIONS - 1);

   typedef logic [IDX_W-1:0] action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_REWARD_RATE   = 2'd0,
      REG_PENALTY_RATE  = 2'd1,
      REG_PENALTY_SHARE = 2'd2
   } reg_index_type;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_SWEEP = 4'b0010,
      S_DRAIN = 4'b0100,
      S_LOAD  = 4'b1000
   } state_type;

   typedef struct packed {
      logic       start;
      logic       issue;
      action_type addr;
      logic       load;
   } cmd_type;

   typedef struct packed {
      logic pass_done;
      logic out_busy;
   } status_type;

   function automatic logic [3:0] low_index(input action_type idx);
      logic [IDX_W+3:0] wide;
      wide = {4'b0000, idx};
      return wide[3:0];
   endfunction

endpackage
`default_nettype wire

/* sv/rpla_if.sv */
// handshake channel interfaces for requests, responses and register writes
`default_nettype none
interface rpla_req_if;
   logic valid;
   logic ready;
   logic is_penalty;
   modport source (output valid, output is_penalty, input ready);
   modport sink (input valid, input is_penalty, output ready);
endinterface

interface rpla_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] action_index;
   logic [15:0] action_probability;
   logic       was_reward;
   logic       convex;
   modport source (output valid, output action_index, output action_probability,
                   output was_reward, output convex, input ready);
   modport sink (input valid, input action_index, input action_probability,
                 input was_reward, input convex, output ready);
endinterface

interface rpla_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* sv/rpla_ctrl.sv */
// sequencer: accepts a beat, sweeps the probability memory, loads the result
`default_nettype none
module rpla_ctrl
   import rpla_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output cmd_type         cmd,
   input  wire status_type status
);

   state_type  state_ff, state_in;
   action_type cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      req_ready = 1'b0;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               cnt_in = '0;
               state_in = S_SWEEP;
            end
         end
         S_SWEEP: begin
            cmd.issue = 1'b1;
            cmd.addr = cnt_ff;
            if (cnt_ff == LAST_ACTION) begin
               state_in = S_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            if (status.pass_done) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            if (!status.out_busy) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

/* sv/rpla_datapath.sv */
// counters, action register, probability memory, update pipeline and result register
`default_nettype none
module rpla_datapath
   import rpla_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type cmd,
   output status_type   status,
   input  wire logic    req_is_penalty,
   rpla_csr_if.sink     csr,
   rpla_rsp_if.source   rsp
);

   logic [RATE_W-1:0] reward_rate_ff, penalty_rate_ff, penalty_share_ff;
   logic [CNT_W-1:0]  succ_ff, fail_ff, succ_inc, fail_inc;
   action_type        action_ff;
   logic              penalty_ff;
   logic              up;

   logic [PROB_W-1:0]      mem [NUM_ACTIONS];
   logic [NUM_ACTIONS-1:0] valid_ff;
   logic [PROB_W-1:0]      rd_data_ff;
   logic                   rd_vld_ff;
   logic                   a_valid_ff;
   action_type             a_addr_ff;

   logic [PROB_W-1:0]   p_a;
   logic                cur_a;
   logic [PROB_W:0]     x_a;
   logic [RATE_W-1:0]   rate_a;
   logic [2*PROB_W:0]   prod_a;

   logic                b_valid_ff, b_cur_ff;
   action_type          b_addr_ff;
   logic [PROB_W-1:0]   b_p_ff;
   logic [PROB_W:0]     b_sc_ff;

   logic [PROB_W-1:0]   new_p, diff_p;
   logic [PROB_W:0]     sum_p;
   logic [PROB_W-1:0]   prev1_ff, prev2_ff, sel_p_ff;
   logic                convex_ff;

   logic                rsp_valid_ff, rsp_reward_ff, rsp_convex_ff;
   logic [3:0]          rsp_index_ff;
   logic [PROB_W-1:0]   rsp_prob_ff;

   assign csr.ready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         reward_rate_ff <= REWARD_RATE_RESET;
         penalty_rate_ff <= PENALTY_RATE_RESET;
         penalty_share_ff <= PENALTY_SHARE_RESET;
      end else if (csr.valid) begin
         unique case (reg_index_type'(csr.index))
            REG_REWARD_RATE:   reward_rate_ff <= csr.data;
            REG_PENALTY_RATE:  penalty_rate_ff <= csr.data;
            REG_PENALTY_SHARE: penalty_share_ff <= csr.data;
            default: ;
         endcase
      end
   end

   // counters and action move
   assign succ_inc = (&succ_ff) ? succ_ff : succ_ff + 1'b1;
   assign fail_inc = (&fail_ff) ? fail_ff : fail_ff + 1'b1;
   assign up = req_is_penalty ? (succ_ff < fail_inc) : (succ_inc > fail_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         succ_ff <= '0;
         fail_ff <= '0;
         action_ff <= '0;
         penalty_ff <= 1'b0;
      end else if (cmd.start) begin
         penalty_ff <= req_is_penalty;
         if (req_is_penalty) begin
            fail_ff <= fail_inc;
         end else begin
            succ_ff <= succ_inc;
         end
         if (up && action_ff != LAST_ACTION) begin
            action_ff <= action_ff + 1'b1;
         end else if (action_ff != '0) begin
            action_ff <= action_ff - 1'b1;
         end
      end
   end

   // memory read stage
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[cmd.addr];
      rd_vld_ff <= valid_ff[cmd.addr];
      a_addr_ff <= cmd.addr;
   end

   // multiply stage
   assign p_a = rd_vld_ff ? rd_data_ff : PROB_RESET;
   assign cur_a = (a_addr_ff == action_ff);
   assign x_a = (!penalty_ff && cur_a) ? ((PROB_W+1)'(65536) - {1'b0, p_a}) : {1'b0, p_a};
   assign rate_a = penalty_ff ? penalty_rate_ff : reward_rate_ff;
   assign prod_a = {{(PROB_W+1){1'b0}}, rate_a} * {{PROB_W{1'b0}}, x_a};

   always_ff @(posedge clock) begin
      b_cur_ff <= cur_a;
      b_addr_ff <= a_addr_ff;
      b_p_ff <= p_a;
      b_sc_ff <= prod_a[2*PROB_W:PROB_W];
   end

   // update and write-back stage
   assign diff_p = b_p_ff - b_sc_ff[PROB_W-1:0];
   assign sum_p = {1'b0, diff_p} + {1'b0, penalty_share_ff};

   always_comb begin
      if (!penalty_ff) begin
         if (b_cur_ff) begin
            new_p = b_p_ff + b_sc_ff[PROB_W-1:0];
         end else begin
            new_p = diff_p;
         end
      end else if (b_cur_ff) begin
         new_p = diff_p;
      end else begin
         new_p = sum_p[PROB_W] ? {PROB_W{1'b1}} : sum_p[PROB_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (b_valid_ff) begin
         mem[b_addr_ff] <= new_p;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= cmd.issue;
         b_valid_ff <= a_valid_ff;
         if (b_valid_ff) begin
            valid_ff[b_addr_ff] <= 1'b1;
         end
      end
   end

   // convexity check on the written stream
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         convex_ff <= 1'b1;
      end else if (b_valid_ff) begin
         if (b_addr_ff >= IDX_W'(2) &&
             ({1'b0, new_p} + {1'b0, prev2_ff}) < {prev1_ff, 1'b0}) begin
            convex_ff <= 1'b0;
         end
         prev2_ff <= prev1_ff;
         prev1_ff <= new_p;
         if (b_cur_ff) begin
            sel_p_ff <= new_p;
         end
      end
   end

   assign status.pass_done = b_valid_ff && (b_addr_ff == LAST_ACTION);
   assign status.out_busy = rsp_valid_ff && !rsp.ready;

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_index_ff <= low_index(action_ff);
         rsp_prob_ff <= sel_p_ff;
         rsp_reward_ff <= !penalty_ff;
         rsp_convex_ff <= convex_ff;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.action_index = rsp_index_ff;
   assign rsp.action_probability = rsp_prob_ff;
   assign rsp.was_reward = rsp_reward_ff;
   assign rsp.convex = rsp_convex_ff;

endmodule
`default_nettype wire

/* sv/reward_penalty_learning_automaton_core.sv */
// top level of the reward-penalty learning automaton
// Each request beat is one environment response (reward or penalty). The core bumps the
// matching saturating counter, moves the current action at most one step, then rewrites all
// NUM_ACTIONS Q0.16 probabilities through a single 16x17 multiplier, one memory read per
// cycle, checking convexity of the new vector as it is written. One response beat follows
// each request. A request passes through the accept state, the sweep over the single read
// port of the probability memory, a drain of the read and multiply stages and the load of
// the response register. A finished response waits in its own register while the next
// request is taken; the next request then holds in its load cycle until that response beat
// is taken.
// Register writes are accepted every cycle.
`default_nettype none
module reward_penalty_learning_automaton_core
   import rpla_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   rpla_req_if.sink    req_chan,
   rpla_rsp_if.source  rsp_chan,
   rpla_csr_if.sink    csr_chan
);

   cmd_type    cmd;
   status_type status;

   rpla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   rpla_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_is_penalty (req_chan.is_penalty),
      .csr            (csr_chan),
      .rsp            (rsp_chan)
   );

endmodule
`default_nettype wire

/* sim/rpla_update_verifier.sv */
// channel monitor that predicts each automaton update and checks the response beats
`timescale 1ns / 1ps
module rpla_update_verifier
   import rpla_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   rpla_req_if       req_mon,
   rpla_rsp_if       rsp_mon,
   rpla_csr_if       csr_mon,
   output int        mismatches,
   output int        awaited
);

   typedef struct packed {
      logic [3:0]  action_index;
      logic [15:0] action_probability;
      logic        was_reward;
      logic        convex;
   } report_type;

   logic [PROB_W-1:0] prob_vec [NUM_ACTIONS];
   action_type        cur_action;
   logic [CNT_W-1:0]  wins;
   logic [CNT_W-1:0]  losses;
   logic [RATE_W-1:0] gain_rate;
   logic [RATE_W-1:0] loss_rate;
   logic [RATE_W-1:0] loss_share;
   report_type        pending_reports [$];
   int                errors;

   function automatic void step_action(input logic up);
      if (up && cur_action != LAST_ACTION) begin
         cur_action = cur_action + 1'b1;
      end else if (cur_action != '0) begin
         cur_action = cur_action - 1'b1;
      end
   endfunction

   function automatic report_type apply_response(input logic pen);
      report_type r;
      longint  p;
      longint  g;
      longint  l;
      longint  d;
      g = longint'(gain_rate);
      l = longint'(loss_rate);
      if (pen) begin
         losses = (losses == '1) ? losses : losses + 1'b1;
         step_action(wins < losses);
      end else begin
         wins = (wins == '1) ? wins : wins + 1'b1;
         step_action(wins > losses);
      end
      for (int i = 0; i < NUM_ACTIONS; i++) begin
         p = longint'(prob_vec[i]);
         if (!pen) begin
            if (i == int'(cur_action)) p = p + ((g * (65536 - p)) >> 16);
            else p = p - ((g * p) >> 16);
         end else begin
            p = p - ((l * p) >> 16);
            if (i != int'(cur_action)) begin
               p = p + longint'(loss_share);
               if (p > 65535) p = 65535;
            end
         end
         prob_vec[i] = p[PROB_W-1:0];
      end
      r.convex = 1'b1;
      for (int i = 0; i + 2 < NUM_ACTIONS; i++) begin
         d = longint'(prob_vec[i+2]) - 2 * longint'(prob_vec[i+1]) + longint'(prob_vec[i]);
         if (d < 0) r.convex = 1'b0;
      end
      r.action_index = cur_action[3:0];
      r.action_probability = prob_vec[cur_action];
      r.was_reward = !pen;
      return r;
   endfunction

   always @(posedge clock) begin
      report_type want;
      report_type got;
      if (reset) begin
         for (int i = 0; i < NUM_ACTIONS; i++) prob_vec[i] = PROB_RESET;
         cur_action = '0;
         wins = '0;
         losses = '0;
         gain_rate = REWARD_RATE_RESET;
         loss_rate = PENALTY_RATE_RESET;
         loss_share = PENALTY_SHARE_RESET;
         pending_reports.delete();
         errors = 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               REG_REWARD_RATE: begin
                  gain_rate = csr_mon.data;
               end
               REG_PENALTY_RATE: begin
                  loss_rate = csr_mon.data;
               end
               REG_PENALTY_SHARE: begin
                  loss_share = csr_mon.data;
               end
               default: begin
               end
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.action_index = rsp_mon.action_index;
            got.action_probability = rsp_mon.action_probability;
            got.was_reward = rsp_mon.was_reward;
            got.convex = rsp_mon.convex;
            if (pending_reports.size() == 0) begin
               $display("%0t: response beat with nothing outstanding, actual %h", $time, got);
               errors++;
            end else begin
               want = pending_reports.pop_front();
               if (got.action_index !== want.action_index) begin
                  $display("%0t: action_index expected %0d actual %0d",
                           $time, want.action_index, got.action_index);
                  errors++;
               end
               if (got.action_probability !== want.action_probability) begin
                  $display("%0t: action_probability expected %h actual %h",
                           $time, want.action_probability, got.action_probability);
                  errors++;
               end
               if (got.was_reward !== want.was_reward) begin
                  $display("%0t: was_reward expected %b actual %b",
                           $time, want.was_reward, got.was_reward);
                  errors++;
               end
               if (got.convex !== want.convex) begin
                  $display("%0t: convex expected %b actual %b",
                           $time, want.convex, got.convex);
                  errors++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            pending_reports.push_back(apply_response(req_mon.is_penalty));
         end
      end
      mismatches <= errors;
      awaited <= pending_reports.size();
   end

endmodule

/* sim/testbench.sv */
// testbench top: stimulus, handshake pacing and verdict for the learning automaton core
`timescale 1ns / 1ps
module testbench
   import rpla_pkg::*;
();

   localparam int STALL_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES = 250;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS = 119;
   localparam logic [CSR_IDX_W-1:0] REG_NONE = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic take_ready = 1'b0;
   logic hold_wanted = 1'b0;
   logic hold_used = 1'b0;
   int   hold_left = 0;
   int   take_gap_pct = 0;
   int   send_gap_pct;
   int   quiet_cycles = 0;
   int   mismatches;
   int   awaited;

   rpla_req_if req_chan ();
   rpla_rsp_if rsp_chan ();
   rpla_csr_if csr_chan ();

   assign rsp_chan.ready = take_ready;

   reward_penalty_learning_automaton_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   rpla_update_verifier update_verifier (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .csr_mon    (csr_chan),
      .mismatches (mismatches),
      .awaited    (awaited)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response side pacing, with one long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         take_ready <= 1'b0;
      end else if (hold_left > 0) begin
         take_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_wanted && !hold_used) begin
         take_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_used <= 1'b1;
      end else begin
         take_ready <= ($urandom_range(99) >= take_gap_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("** reward_penalty_learning_automaton_core: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_response(input logic pen);
      while ($urandom_range(99) < send_gap_pct) begin
         req_chan.valid <= 1'b0;
         req_chan.is_penalty <= 1'($urandom_range(1));
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.is_penalty <= pen;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [RATE_W-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data <= value;
      do @(posedge clock); while (!csr_chan.ready);
   endtask

   // all three rates plus a write to the unused index, which must change nothing
   task automatic load_rates(input logic [RATE_W-1:0] gain, input logic [RATE_W-1:0] loss,
                             input logic [RATE_W-1:0] share);
      write_reg(REG_REWARD_RATE, gain);
      write_reg(REG_PENALTY_RATE, loss);
      write_reg(REG_PENALTY_SHARE, share);
      write_reg(REG_NONE, RATE_W'($urandom_range(65535)));
      csr_chan.valid <= 1'b0;
   endtask

   task automatic drain;
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (awaited != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [RATE_W-1:0] pick_rate;
      case ($urandom_range(3))
         0: pick_rate = '0;
         1: pick_rate = '1;
         2: pick_rate = RATE_W'($urandom_range(8192));
         default: pick_rate = RATE_W'($urandom_range(65535));
      endcase
   endfunction

   initial begin
      req_chan.valid <= 1'b0;
      req_chan.is_penalty <= 1'b0;
      csr_chan.valid <= 1'b0;
      csr_chan.index <= REG_REWARD_RATE;
      csr_chan.data <= '0;
      send_gap_pct = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // climb to the top action and bounce there, then turn back with penalties
      repeat (17) send_response(1'b0);
      repeat (3) send_response(1'b1);
      drain();
      // full-scale share drives penalty updates into saturation
      load_rates('1, '0, '1);
      repeat (3) send_response(1'b1);
      repeat (2) send_response(1'b0);
      drain();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph == 0) load_rates('0, '0, '0);
         else if (ph == 1) load_rates('1, '1, '1);
         else load_rates(pick_rate(), pick_rate(), pick_rate());
         if (ph < 4) begin
            send_gap_pct = 34;
            take_gap_pct <= 68;
         end else if (ph < 8) begin
            send_gap_pct = 68;
            take_gap_pct <= 34;
         end else begin
            send_gap_pct = 0;
            take_gap_pct <= 0;
         end
         if (ph == 8) hold_wanted <= 1'b1;
         begin
            int pen_pct;
            pen_pct = $urandom_range(15, 85);
            repeat (PHASE_ITEMS) send_response($urandom_range(99) < pen_pct);
         end
         drain();
      end

      if (mismatches == 0 && awaited == 0) begin
         $display("** reward_penalty_learning_automaton_core: PASSED **");
      end else begin
         $display("** reward_penalty_learning_automaton_core: FAILED **");
      end
      $finish;
   end

endmodule
